// ===== hw/rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

   // Default geometry
   localparam int COLS_DEF     = 80;
   localparam int ROWS_DEF     = 25;
   localparam int TAB_STOP_DEF = 8;

   localparam logic [7:0] DEFAULT_COLOR_RESET = 8'h07;

   // Character codes
   localparam logic [7:0] CH_LF         = 8'h0A;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_BS         = 8'h08;
   localparam logic [7:0] CH_BLANK      = 8'h20;
   localparam logic [7:0] CH_PRINT_LAST = 8'h7F;

   // Operation codes
   localparam logic [1:0] FUNC_PRINT     = 2'd0;
   localparam logic [1:0] FUNC_SET_PRINT = 2'd1;
   localparam logic [1:0] FUNC_CLEAR     = 2'd2;
   localparam logic [1:0] FUNC_READ      = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] character;
      logic [7:0] attribute;
      logic [6:0] col;
      logic [4:0] row;
   } req_type;

   typedef struct packed {
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic [10:0] cursor_offset;
      logic        scrolled;
      logic [7:0]  read_char;
      logic [7:0]  read_attr;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // latch incoming item
      logic plan;       // decode item, move cursor, read cell
      logic commit;     // write planned cell
      logic sweep_clr;  // restart sweep counter
      logic fill;       // blank cell at sweep address
      logic init_fill;  // blank uses reset color
      logic scroll;     // copy step of the scroll sweep
      logic finish;     // load result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scroll;
      logic clear;
      logic sweep_last;
   } stat_type;

endpackage

// ===== hw/rtl/tcw_ctrl.sv =====
`timescale 1ns / 1ps

module tcw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  tcw_pkg::stat_type stat,
   output tcw_pkg::cmd_type  cmd
);
   import tcw_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_PLAN,
      ST_COMMIT,
      ST_SCROLL,
      ST_FILL,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      ready;
   logic      accept;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign accept    = ready && req_valid;
   assign req_stall = !ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd   = '0;
      ready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.fill      = 1'b1;
            cmd.init_fill = 1'b1;
         end
         ST_IDLE: begin
            ready = 1'b1;
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            if (stat.scroll || stat.clear) begin
               cmd.sweep_clr = 1'b1;
            end else if (out_free) begin
               cmd.finish = 1'b1;
               ready      = 1'b1;
            end
         end
         ST_SCROLL: begin
            cmd.scroll = 1'b1;
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = out_free;
         end
         default: begin
            cmd   = '0;
            ready = 1'b0;
         end
      endcase
      cmd.load = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_INIT: begin
               if (stat.sweep_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (accept) state_ff <= ST_PLAN;
            end
            ST_PLAN: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (stat.scroll) begin
                  state_ff <= ST_SCROLL;
               end else if (stat.clear) begin
                  state_ff <= ST_FILL;
               end else if (out_free) begin
                  state_ff <= accept ? ST_PLAN : ST_IDLE;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_SCROLL: begin
               if (stat.sweep_last) state_ff <= ST_FINISH;
            end
            ST_FILL: begin
               if (stat.sweep_last) state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/tcw_datapath.sv =====
`timescale 1ns / 1ps

module tcw_datapath #(
   parameter int COLS     = tcw_pkg::COLS_DEF,
   parameter int ROWS     = tcw_pkg::ROWS_DEF,
   parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  tcw_pkg::cmd_type  cmd,
   output tcw_pkg::stat_type stat,
   input  tcw_pkg::req_type  req_item,
   input  logic [7:0]        color,
   output tcw_pkg::rsp_type  rsp_item
);
   import tcw_pkg::*;

   localparam int CELLS = COLS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLS);
   localparam int RW    = $clog2(ROWS);
   localparam int TW    = $clog2(COLS + TAB_STOP);
   // tab stop quotient by reciprocal; exact for columns below 256
   localparam int TAB_SH = 12;
   localparam int TAB_M  = (2 ** TAB_SH + TAB_STOP - 1) / TAB_STOP;
   localparam int PW     = CW + TAB_SH + 1;

   logic [15:0]   mem [CELLS];

   req_type       item_ff;
   logic [CW-1:0] col_ff,  col_in;
   logic [RW-1:0] line_ff, line_in;
   logic          wr_en_ff,   wr_en_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic [15:0]   wr_data_ff, wr_data_in;
   logic          scroll_ff,  scroll_in;
   logic          clear_ff;
   logic          rd_ok_ff;
   logic [15:0]   rd_data_ff;
   logic [AW-1:0] sweep_ff;
   logic          pipe_we_ff;
   logic [AW-1:0] pipe_addr_ff;
   logic          pipe_blank_ff;
   rsp_type       rsp_ff;

   // item decode
   logic          in_range, set_pos, do_print;
   logic [CW-1:0] base_col, wcol;
   logic [RW-1:0] base_line;
   logic [7:0]    eff_attr, wchar;
   logic [PW-1:0] tab_prod;
   logic [TW-1:0] tab_col, pre_col;
   logic [RW:0]   pre_line, line_after;
   logic          wrap;
   logic [AW-1:0] rd_addr;

   // memory ports
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr, scroll_raddr;
   logic [15:0]   mem_wdata;
   logic [7:0]    fill_color;
   logic [AW:0]   scroll_sum;
   logic          sweep_last;

   assign in_range = (int'(item_ff.col) < COLS) && (int'(item_ff.row) < ROWS);
   assign set_pos  = (item_ff.func == FUNC_SET_PRINT) && in_range;
   assign do_print = (item_ff.func == FUNC_PRINT) || set_pos;
   assign base_col  = set_pos ? CW'(item_ff.col) : col_ff;
   assign base_line = set_pos ? RW'(item_ff.row) : line_ff;
   assign eff_attr  = (item_ff.attribute == 8'h00) ? color : item_ff.attribute;

   assign tab_prod = PW'(base_col * TAB_M);
   assign tab_col  = TW'((int'(tab_prod[PW-1:TAB_SH]) + 1) * TAB_STOP);

   assign rd_addr = in_range ? AW'(int'(item_ff.row) * COLS + int'(item_ff.col)) : '0;

   always_comb begin
      pre_col  = TW'(base_col);
      pre_line = (RW+1)'(base_line);
      wcol     = base_col;
      wchar    = item_ff.character;
      wr_en_in = 1'b0;
      case (item_ff.character)
         CH_LF: begin
            pre_col  = '0;
            pre_line = (RW+1)'(base_line) + (RW+1)'(1);
         end
         CH_CR: begin
            pre_col = '0;
         end
         CH_TAB: begin
            pre_col = tab_col;
         end
         CH_BS: begin
            wcol     = (base_col == '0) ? '0 : base_col - CW'(1);
            pre_col  = TW'(wcol);
            wchar    = CH_BLANK;
            wr_en_in = 1'b1;
         end
         default: begin
            if (item_ff.character >= CH_BLANK && item_ff.character <= CH_PRINT_LAST) begin
               wr_en_in = 1'b1;
               pre_col  = TW'(base_col) + TW'(1);
            end
         end
      endcase
      if (!do_print) begin
         wr_en_in = 1'b0;
         pre_col  = TW'(col_ff);
         pre_line = (RW+1)'(line_ff);
         if (item_ff.func == FUNC_CLEAR) begin
            pre_col  = '0;
            pre_line = '0;
         end
      end
   end

   // wrap past last column, scroll past last row
   assign wrap       = int'(pre_col) >= COLS;
   assign line_after = pre_line + (RW+1)'(wrap);
   assign scroll_in  = int'(line_after) >= ROWS;
   assign col_in     = wrap ? '0 : CW'(pre_col);
   assign line_in    = scroll_in ? RW'(ROWS - 1) : RW'(line_after);
   assign wr_addr_in = AW'(int'(base_line) * COLS) + AW'(wcol);
   assign wr_data_in = {eff_attr, wchar};

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_item;
      if (cmd.plan) begin
         wr_addr_ff <= wr_addr_in;
         wr_data_ff <= wr_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         line_ff    <= '0;
         wr_en_ff   <= 1'b0;
         scroll_ff  <= 1'b0;
         clear_ff   <= 1'b0;
         rd_ok_ff   <= 1'b0;
         sweep_ff   <= '0;
         pipe_we_ff <= 1'b0;
      end else begin
         if (cmd.plan) begin
            col_ff    <= col_in;
            line_ff   <= line_in;
            wr_en_ff  <= wr_en_in;
            scroll_ff <= scroll_in;
            clear_ff  <= item_ff.func == FUNC_CLEAR;
            rd_ok_ff  <= (item_ff.func == FUNC_READ) && in_range;
         end
         if (cmd.sweep_clr) begin
            sweep_ff <= '0;
         end else if (cmd.fill || cmd.scroll) begin
            sweep_ff <= sweep_last ? '0 : sweep_ff + AW'(1);
         end
         pipe_we_ff <= cmd.scroll;
      end
   end

   // scroll: read row below, write it in the following cycle; bottom row gets blanks
   assign sweep_last   = sweep_ff == AW'(CELLS - 1);
   assign scroll_sum   = (AW+1)'(sweep_ff) + (AW+1)'(COLS);
   assign scroll_raddr = (int'(scroll_sum) < CELLS) ? AW'(scroll_sum) : '0;

   always_ff @(posedge clock) begin
      pipe_addr_ff  <= sweep_ff;
      pipe_blank_ff <= int'(sweep_ff) >= (CELLS - COLS);
   end

   assign fill_color = cmd.init_fill ? DEFAULT_COLOR_RESET : color;
   assign mem_raddr  = cmd.scroll ? scroll_raddr : rd_addr;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = sweep_ff;
      mem_wdata = {fill_color, CH_BLANK};
      if (cmd.commit && wr_en_ff) begin
         mem_we    = 1'b1;
         mem_waddr = wr_addr_ff;
         mem_wdata = wr_data_ff;
      end else if (pipe_we_ff) begin
         mem_we    = 1'b1;
         mem_waddr = pipe_addr_ff;
         mem_wdata = pipe_blank_ff ? {color, CH_BLANK} : rd_data_ff;
      end else if (cmd.fill) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.cursor_col    <= 7'(col_ff);
         rsp_ff.cursor_row    <= 5'(line_ff);
         rsp_ff.cursor_offset <= 11'(int'(line_ff) * COLS + int'(col_ff));
         rsp_ff.scrolled      <= scroll_ff;
         rsp_ff.read_char     <= rd_ok_ff ? rd_data_ff[7:0]  : 8'h00;
         rsp_ff.read_attr     <= rd_ok_ff ? rd_data_ff[15:8] : 8'h00;
      end
   end

   assign rsp_item        = rsp_ff;
   assign stat.scroll     = scroll_ff;
   assign stat.clear      = clear_ff;
   assign stat.sweep_last = sweep_last;

endmodule

// ===== hw/rtl/text_console_writer.sv =====
`timescale 1ns / 1ps

// Text console engine: a COLS x ROWS store of 16-bit cells (attribute in the
// high byte, character in the low byte) and a cursor. Each request is print at
// cursor, set position and print, clear, or read one cell; each gives exactly
// one response with the cursor after the operation, its linear offset, a
// scroll flag and the read cell. Prints and reads run back to back while
// the response side does not stall: the plan state decodes the item and
// forms the cell address (one multiply), the commit state writes the cell
// through the single write port of the store. A clear walks every cell
// through that port; a print that scrolls copies every row up one and blanks
// the last. After reset the store is swept to blank cells in color 7, during
// which req_stall is high. A request is taken while the previous response
// still waits in the output register. The user must write the default color
// on the csr port only while no request is in flight; the block itself does
// not enforce it.
module text_console_writer #(
   parameter int COLS     = tcw_pkg::COLS_DEF,
   parameter int ROWS     = tcw_pkg::ROWS_DEF,
   parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  tcw_pkg::req_type req_item,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tcw_pkg::rsp_type rsp_item,
   // default color register
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_wdata
);
   import tcw_pkg::*;

   logic [7:0] color_ff;
   cmd_type    cmd;
   stat_type   stat;

   // register transfer always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= DEFAULT_COLOR_RESET;
      end else if (csr_valid && csr_ready) begin
         color_ff <= csr_wdata;
      end
   end

   // sequencing: accept, plan, commit, sweeps, response
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // cursor, cell store, sweep counter and response register
   tcw_datapath #(
      .COLS     (COLS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_item (req_item),
      .color    (color_ff),
      .rsp_item (rsp_item)
   );

endmodule

// ===== test/text_console_writer_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the text console engine. Requests are queued by the
// stimulus process, fed in bursts by a clocked driver, and predicted on the
// transfer edge against a local copy of the screen and cursor. The monitor
// pops the oldest prediction for every response transfer and compares it
// field by field.
module text_console_writer_tb;
   import tcw_pkg::*;

   localparam int COLS        = COLS_DEF;
   localparam int ROWS        = ROWS_DEF;
   localparam int TAB         = TAB_STOP_DEF;
   localparam int CELLS       = COLS * ROWS;
   localparam int PHASE_ITEMS = 400;
   // a scroll or clear sweep walks all CELLS cells; every request sweeping
   // plus stalls and gaps stays far below this
   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int LONG_HOLD   = 120;
   localparam int TAIL_CYCLES = 40;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_item  = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_item;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_wdata = 8'h00;

   text_console_writer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Local screen image and cursor, advanced once per accepted request
   // ---------------------------------------------------------------------
   logic [15:0] screen [CELLS];
   int          cur_col;
   int          cur_row;
   logic [7:0]  color_reg;

   rsp_type     cursor_reports [$];   // predicted responses, oldest first
   req_type     console_backlog [$];  // requests not yet offered
   rsp_type     oldest_report;

   int errors       = 0;
   int items_queued = 0;
   int items_sent   = 0;
   int rsp_count    = 0;   // response transfers, updated with NBA only
   int scroll_count = 0;
   int clear_count  = 0;
   int read_count   = 0;
   int color_writes = 0;
   int cycle_count  = 0;

   // stimulus helpers: last in-range set position, so reads land near text
   int last_col = 0;
   int last_row = 0;

   function automatic logic [15:0] blank_cell();
      return {color_reg, CH_BLANK};
   endfunction

   function automatic void fill_screen();
      for (int i = 0; i < CELLS; i++) screen[i] = blank_cell();
   endfunction

   // wrap past the last column, scroll past the last row
   function automatic bit settle_cursor();
      if (cur_col >= COLS) begin
         cur_col = 0;
         cur_row++;
      end
      if (cur_row >= ROWS) begin
         for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
         for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = blank_cell();
         cur_row = ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit print_byte(logic [7:0] ch, logic [7:0] attr);
      logic [7:0] eff;
      eff = (attr == 8'h00) ? color_reg : attr;
      if (ch == CH_LF) begin
         cur_col = 0;
         cur_row++;
      end else if (ch == CH_CR) begin
         cur_col = 0;
      end else if (ch == CH_TAB) begin
         cur_col = (cur_col / TAB + 1) * TAB;
      end else if (ch == CH_BS) begin
         if (cur_col != 0) cur_col--;
         screen[cur_row * COLS + cur_col] = {eff, CH_BLANK};
      end else if (ch >= CH_BLANK && ch <= CH_PRINT_LAST) begin
         screen[cur_row * COLS + cur_col] = {eff, ch};
         cur_col++;
      end
      // any other byte only runs the wrap/scroll check
      return settle_cursor();
   endfunction

   function automatic rsp_type console_step(req_type it);
      rsp_type r;
      bit      in_range;
      r        = '0;
      in_range = (it.col < COLS) && (it.row < ROWS);
      case (it.func)
         FUNC_PRINT: begin
            r.scrolled = print_byte(it.character, it.attribute);
         end
         FUNC_SET_PRINT: begin
            // out-of-range position: no move, no print
            if (in_range) begin
               cur_col    = int'(it.col);
               cur_row    = int'(it.row);
               r.scrolled = print_byte(it.character, it.attribute);
            end
         end
         FUNC_CLEAR: begin
            fill_screen();
            cur_col = 0;
            cur_row = 0;
            clear_count++;
         end
         FUNC_READ: begin
            if (in_range) {r.read_attr, r.read_char} = screen[it.row * COLS + it.col];
            read_count++;
         end
      endcase
      r.cursor_col    = 7'(cur_col);
      r.cursor_row    = 5'(cur_row);
      r.cursor_offset = 11'(cur_row * COLS + cur_col);
      if (r.scrolled) scroll_count++;
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         errors++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   function automatic req_type request(logic [1:0] func, logic [7:0] ch, logic [7:0] attr,
                                       logic [6:0] col, logic [4:0] row);
      req_type it;
      it.func      = func;
      it.character = ch;
      it.attribute = attr;
      it.col       = col;
      it.row       = row;
      return it;
   endfunction

   // mostly prints, some positioned prints and reads, rare clears;
   // each coordinate is off screen about one time in ten
   function automatic req_type random_request();
      req_type it;
      int      pick;
      int      k;
      it.attribute = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
      it.col       = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(COLS, 127))
                                                 : 7'($urandom_range(0, COLS - 1));
      it.row       = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(ROWS, 31))
                                                 : 5'($urandom_range(0, ROWS - 1));
      k = $urandom_range(0, 99);
      if (k < 8)       it.character = CH_LF;
      else if (k < 12) it.character = CH_CR;
      else if (k < 16) it.character = CH_TAB;
      else if (k < 21) it.character = CH_BS;
      else if (k < 31) it.character = 8'($urandom_range(0, 255));
      else             it.character = 8'($urandom_range(CH_BLANK, CH_PRINT_LAST));
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         it.func = FUNC_PRINT;
      end else if (pick < 75) begin
         it.func = FUNC_SET_PRINT;
         if (it.col < COLS && it.row < ROWS) begin
            last_col = int'(it.col);
            last_row = int'(it.row);
         end
      end else if (pick < 76) begin
         it.func = FUNC_CLEAR;
      end else begin
         it.func = FUNC_READ;
         // half the reads look at or just past a recent print position
         if (pick < 88) begin
            it.col = 7'((last_col + $urandom_range(0, 3)) % COLS);
            it.row = 5'(last_row);
         end
      end
      return it;
   endfunction

   task automatic queue_request(req_type it);
      console_backlog.push_back(it);
      items_queued++;
   endtask

   // sender pause: hold off until every queued request has its response
   task automatic wait_all_answered();
      while (rsp_count != items_queued) @(posedge clock);
   endtask

   task automatic write_color(logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      color_reg = value;
      color_writes++;
   endtask

   // ---------------------------------------------------------------------
   // Driver: bursts of random length, random gaps, predicts on transfer
   // ---------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            cursor_reports.push_back(console_step(req_item));
            items_sent++;
         end
         // slot is free when nothing is offered or the offer just transferred
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (console_backlog.size() != 0) begin
               req_valid <= 1'b1;
               req_item  <= console_backlog.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response stall pattern: random modes, plus a long hold-off now and then
   // so the block backs up and stalls its request side
   // ---------------------------------------------------------------------
   int hold_cnt     = 0;
   int next_hold_at = 300;
   int stall_mode   = 0;
   int mode_left    = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else if (rsp_count >= next_hold_at) begin
         hold_cnt     = LONG_HOLD;
         next_hold_at = next_hold_at + 700;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0:       rsp_stall <= 1'b0;                        // no back-pressure
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;                  // alternating
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare every response transfer with the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count <= rsp_count + 1;
         if (cursor_reports.size() == 0) begin
            errors++;
            $error("response with no request outstanding: %p", rsp_item);
         end else begin
            oldest_report = cursor_reports.pop_front();
            check_field("cursor_col", 32'(oldest_report.cursor_col),
                        32'(rsp_item.cursor_col));
            check_field("cursor_row", 32'(oldest_report.cursor_row),
                        32'(rsp_item.cursor_row));
            check_field("cursor_offset", 32'(oldest_report.cursor_offset),
                        32'(rsp_item.cursor_offset));
            check_field("scrolled", 32'(oldest_report.scrolled),
                        32'(rsp_item.scrolled));
            check_field("read_char", 32'(oldest_report.read_char),
                        32'(rsp_item.read_char));
            check_field("read_attr", 32'(oldest_report.read_attr),
                        32'(rsp_item.read_attr));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("timeout: %0d requests sent, %0d responses", items_sent, rsp_count);
         $display("text_console_writer_tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus: directed corner cases, then random phases under several
   // default colors, each phase drained before the color changes
   // ---------------------------------------------------------------------
   logic [7:0] phase_color;

   initial begin
      color_reg = DEFAULT_COLOR_RESET;
      cur_col   = 0;
      cur_row   = 0;
      fill_screen();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // blank screen after reset, default and explicit attributes
      queue_request(request(FUNC_READ,      8'h00,         8'h00, 7'd0,   5'd0));
      queue_request(request(FUNC_PRINT,     8'h41,         8'h00, 7'd0,   5'd0));
      queue_request(request(FUNC_PRINT,     8'h42,         8'hFF, 7'd0,   5'd0));
      // control codes and edges of the printable range
      queue_request(request(FUNC_PRINT,     CH_TAB,        8'h00, 7'd0,   5'd0));
      queue_request(request(FUNC_PRINT,     CH_BS,         8'h81, 7'd0,   5'd0));
      queue_request(request(FUNC_PRINT,     CH_PRINT_LAST, 8'h42, 7'd0,   5'd0));
      queue_request(request(FUNC_PRINT,     8'h80,         8'h11, 7'd0,   5'd0));
      queue_request(request(FUNC_PRINT,     8'hFF,         8'h11, 7'd0,   5'd0));
      queue_request(request(FUNC_PRINT,     CH_CR,         8'h00, 7'd0,   5'd0));
      queue_request(request(FUNC_PRINT,     CH_LF,         8'h00, 7'd0,   5'd0));
      // wrap off the last column
      queue_request(request(FUNC_SET_PRINT, 8'h5A,         8'h00, 7'd79,  5'd0));
      // off-screen positions are ignored
      queue_request(request(FUNC_SET_PRINT, 8'h71,         8'hFF, 7'd127, 5'd31));
      queue_request(request(FUNC_SET_PRINT, 8'h71,         8'h00, 7'd80,  5'd3));
      queue_request(request(FUNC_SET_PRINT, 8'h71,         8'h00, 7'd5,   5'd25));
      // backspace at column zero
      queue_request(request(FUNC_SET_PRINT, CH_BS,         8'h3C, 7'd0,   5'd5));
      // scroll by wrap, by tab past the last column, by newline
      queue_request(request(FUNC_SET_PRINT, 8'h78,         8'h00, 7'd79,  5'd24));
      queue_request(request(FUNC_SET_PRINT, CH_TAB,        8'h00, 7'd75,  5'd24));
      queue_request(request(FUNC_SET_PRINT, CH_LF,         8'h00, 7'd0,   5'd24));
      queue_request(request(FUNC_READ,      8'h00,         8'h00, 7'd79,  5'd21));
      // off-screen reads return zero
      queue_request(request(FUNC_READ,      8'hFF,         8'hFF, 7'd127, 5'd31));
      queue_request(request(FUNC_READ,      8'h00,         8'h00, 7'd0,   5'd30));
      queue_request(request(FUNC_PRINT,     CH_BLANK,      8'h00, 7'd0,   5'd0));
      // clear, then look at both corners
      queue_request(request(FUNC_CLEAR,     8'hFF,         8'hFF, 7'd127, 5'd31));
      queue_request(request(FUNC_READ,      8'h00,         8'h00, 7'd0,   5'd0));
      queue_request(request(FUNC_READ,      8'h00,         8'h00, 7'd79,  5'd24));
      wait_all_answered();

      // color extremes first, then a mid value, a random one, the reset value
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       phase_color = 8'h00;
            1:       phase_color = 8'hFF;
            2:       phase_color = 8'h5A;
            3:       phase_color = 8'($urandom_range(1, 254));
            default: phase_color = DEFAULT_COLOR_RESET;
         endcase
         write_color(phase_color);
         repeat (PHASE_ITEMS) queue_request(random_request());
         wait_all_answered();
      end

      // catch any stray response after the last one expected
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d requests with %0d default colors: %0d reads, %0d clears,",
               items_sent, color_writes, read_count, clear_count);
      $display("%0d scrolls, long response hold-offs and full drains between phases",
               scroll_count);
      if (errors == 0) begin
         $display("text_console_writer_tb: done, clean");
      end else begin
         $display("text_console_writer_tb: done, errors");
      end
      $finish;
   end

endmodule
